/* rtl/rabg_pkg.sv */
// shared types, codes and helpers for the rational arithmetic gcd unit
package rabg_pkg;

	// operand width used from each input field (low bits, sign-extended)
	localparam int OPERAND_BITS = 32;
	localparam int OP_W         = 32;
	localparam int PROD_W       = 2 * OP_W;

	// command codes
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_RED = 3'd4;

	// status codes
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_WRAP = 2'd2;

	typedef struct packed {
		logic [2:0]             cmd;
		logic signed [OP_W-1:0] a_num;
		logic signed [OP_W-1:0] a_den;
		logic signed [OP_W-1:0] b_num;
		logic signed [OP_W-1:0] b_den;
	} operands_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] res_num;
		logic signed [PROD_W-1:0] res_den;
		logic [1:0]               status;
	} result_t;

	// keep the low OPERAND_BITS bits and sign-extend from the top one
	function automatic logic signed [OP_W-1:0] sext_op(input logic [OP_W-1:0] v);
		logic [OP_W-1:0] t;
		t = v << (OP_W - OPERAND_BITS);
		return $signed(t) >>> (OP_W - OPERAND_BITS);
	endfunction

endpackage

/* rtl/rabg_mul.sv */
// registered signed operand multiplier shared by the product phase
module rabg_mul (
	input  logic                              clk,
	input  logic signed [rabg_pkg::OP_W-1:0]   x,
	input  logic signed [rabg_pkg::OP_W-1:0]   y,
	output logic signed [rabg_pkg::PROD_W-1:0] prod
);
	import rabg_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	// full product always fits, no wrap possible
	always_ff @(posedge clk) begin
		prod_q <= x * y;
	end

	assign prod = prod_q;

endmodule

/* rtl/rational_arith_binary_gcd_unit.sv */
// rational add/sub/mul/div/reduce with binary gcd reduction, sequenced over one shared adder
// sequence: three products, form, magnitude of each side, binary gcd by shifts, swaps and
//   subtracts, rescale shifts, then two bit-serial division passes (numerator, denominator)
// throughput: one transaction at a time; busy stays high until the result strobe
// the gcd loop and the bit-serial divider both run through the single 64-bit adder
// reset: arst_n clears the sequencer and the done strobe; the receiver cannot stall
module rational_arith_binary_gcd_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rabg_pkg::operands_t operands,
	output logic                busy,
	output logic                done,
	output rabg_pkg::result_t   result
);
	import rabg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_FORM,
		ST_MAG_NUM,
		ST_MAG_DEN,
		ST_GCD_INIT,
		ST_GCD_TWO,
		ST_GCD_UODD,
		ST_GCD_LOOP,
		ST_GCD_SHL,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_SIGN
	} state_t;

	state_t state_q;

	// latched operands, already sign-extended
	logic [2:0]               cmd_q;
	logic signed [OP_W-1:0]   an_q, ad_q, bn_q, bd_q;

	// products and raw fraction
	logic [PROD_W-1:0]        p_q, q_q;
	logic [PROD_W-1:0]        num_q, den_q;
	logic                     wrap_q;

	// magnitudes and gcd working set
	logic [PROD_W-1:0]        magn_q, magd_q;
	logic [PROD_W-1:0]        u_q, v_q, g_q;
	logic [5:0]               shift_q;

	// bit-serial divider
	logic [PROD_W-1:0]        rem_q, dvd_q;
	logic [5:0]               cnt_q;
	logic                     sel_den_q;

	logic                     done_q;
	result_t                  res_q;

	// shared multiplier
	logic signed [OP_W-1:0]   mul_x, mul_y;
	logic signed [PROD_W-1:0] prod;

	// shared 64-bit adder / subtractor
	logic [PROD_W-1:0]        alu_a, alu_b, alu_res;
	logic                     alu_sub, alu_carry;
	logic [PROD_W:0]          alu_sum;

	// per-state helpers
	logic [PROD_W-1:0]        an_ext, ad_ext, div_try;
	logic                     sum_wrap, diff_wrap, res_sign;
	logic [PROD_W-1:0]        signed_q;

	rabg_mul u_mul (
		.clk  (clk),
		.x    (mul_x),
		.y    (mul_y),
		.prod (prod)
	);

	assign an_ext  = PROD_W'(an_q);
	assign ad_ext  = PROD_W'(ad_q);
	assign div_try = {rem_q[PROD_W-2:0], dvd_q[PROD_W-1]};

	// multiplier operand pairs, one per product cycle
	always_comb begin
		mul_x = an_q;
		mul_y = bd_q;
		case (state_q)
			ST_MUL0: begin
				mul_x = an_q;
				mul_y = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			ST_MUL1: begin
				mul_x = bn_q;
				mul_y = ad_q;
			end
			ST_MUL2: begin
				mul_x = ad_q;
				mul_y = (cmd_q == CMD_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_x = an_q;
				mul_y = bd_q;
			end
		endcase
	end

	// adder operand selection by sequencer state
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			ST_FORM: begin
				alu_a   = p_q;
				alu_b   = q_q;
				alu_sub = (cmd_q == CMD_SUB);
			end
			ST_MAG_NUM: alu_b = num_q;
			ST_MAG_DEN: alu_b = den_q;
			ST_GCD_LOOP: begin
				alu_a = v_q;
				alu_b = u_q;
			end
			ST_DIV_STEP: begin
				alu_a = div_try;
				alu_b = g_q;
			end
			ST_DIV_SIGN: alu_b = dvd_q;
			default: alu_sub = 1'b1;
		endcase
	end

	assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ {{PROD_W{1'b0}}, alu_sub};
	assign alu_res   = alu_sum[PROD_W-1:0];
	assign alu_carry = alu_sum[PROD_W];

	// signed overflow of the cross-product sum or difference
	assign sum_wrap  = ~(p_q[PROD_W-1] ^ q_q[PROD_W-1]) & (alu_res[PROD_W-1] ^ p_q[PROD_W-1]);
	assign diff_wrap = (p_q[PROD_W-1] ^ q_q[PROD_W-1]) & (alu_res[PROD_W-1] ^ p_q[PROD_W-1]);

	// quotient gets the sign of the side being divided
	assign res_sign = sel_den_q ? den_q[PROD_W-1] : num_q[PROD_W-1];
	assign signed_q = res_sign ? alu_res : dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			cmd_q     <= CMD_ADD;
			an_q      <= '0;
			ad_q      <= '0;
			bn_q      <= '0;
			bd_q      <= '0;
			p_q       <= '0;
			q_q       <= '0;
			num_q     <= '0;
			den_q     <= '0;
			wrap_q    <= 1'b0;
			magn_q    <= '0;
			magd_q    <= '0;
			u_q       <= '0;
			v_q       <= '0;
			g_q       <= '0;
			shift_q   <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			cnt_q     <= '0;
			sel_den_q <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= operands.cmd;
						an_q    <= sext_op(operands.a_num);
						ad_q    <= sext_op(operands.a_den);
						bn_q    <= sext_op(operands.b_num);
						bd_q    <= sext_op(operands.b_den);
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: begin
					p_q     <= prod;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					q_q     <= prod;
					state_q <= ST_FORM;
				end
				ST_FORM: begin
					// third product is on the multiplier output now
					case (cmd_q)
						CMD_ADD: begin
							num_q  <= alu_res;
							den_q  <= prod;
							wrap_q <= sum_wrap;
						end
						CMD_SUB: begin
							num_q  <= alu_res;
							den_q  <= prod;
							wrap_q <= diff_wrap;
						end
						CMD_MUL, CMD_DIV: begin
							num_q  <= p_q;
							den_q  <= prod;
							wrap_q <= 1'b0;
						end
						default: begin
							// reduce and unused codes
							num_q  <= an_ext;
							den_q  <= ad_ext;
							wrap_q <= 1'b0;
						end
					endcase
					state_q <= ST_MAG_NUM;
				end
				ST_MAG_NUM: begin
					if (num_q == '0 && den_q == '0) begin
						res_q.res_num <= '0;
						res_q.res_den <= '0;
						res_q.status  <= STATUS_ZERO;
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						magn_q  <= num_q[PROD_W-1] ? alu_res : num_q;
						u_q     <= num_q[PROD_W-1] ? alu_res : num_q;
						state_q <= ST_MAG_DEN;
					end
				end
				ST_MAG_DEN: begin
					magd_q  <= den_q[PROD_W-1] ? alu_res : den_q;
					v_q     <= den_q[PROD_W-1] ? alu_res : den_q;
					state_q <= ST_GCD_INIT;
				end
				ST_GCD_INIT: begin
					shift_q <= '0;
					if (u_q == '0) begin
						g_q     <= v_q;
						state_q <= ST_DIV_LOAD;
					end else if (v_q == '0) begin
						g_q     <= u_q;
						state_q <= ST_DIV_LOAD;
					end else begin
						state_q <= ST_GCD_TWO;
					end
				end
				ST_GCD_TWO: begin
					// strip common factors of two
					if (u_q[0] | v_q[0]) begin
						state_q <= ST_GCD_UODD;
					end else begin
						u_q     <= u_q >> 1;
						v_q     <= v_q >> 1;
						shift_q <= shift_q + 6'd1;
					end
				end
				ST_GCD_UODD: begin
					if (u_q[0]) begin
						state_q <= ST_GCD_LOOP;
					end else begin
						u_q <= u_q >> 1;
					end
				end
				ST_GCD_LOOP: begin
					// u stays odd; v is halved, swapped or reduced by u
					if (v_q == '0) begin
						g_q     <= u_q;
						state_q <= ST_GCD_SHL;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (!alu_carry) begin
						u_q <= v_q;
						v_q <= u_q;
					end else begin
						v_q <= alu_res;
					end
				end
				ST_GCD_SHL: begin
					// restore the common power of two
					if (shift_q == '0) begin
						state_q <= ST_DIV_LOAD;
					end else begin
						g_q     <= g_q << 1;
						shift_q <= shift_q - 6'd1;
					end
				end
				ST_DIV_LOAD: begin
					rem_q     <= '0;
					dvd_q     <= magn_q;
					cnt_q     <= 6'(PROD_W - 1);
					sel_den_q <= 1'b0;
					state_q   <= ST_DIV_STEP;
				end
				ST_DIV_STEP: begin
					// restoring division, one quotient bit per cycle
					rem_q <= alu_carry ? alu_res : div_try;
					dvd_q <= {dvd_q[PROD_W-2:0], alu_carry};
					if (cnt_q == '0) begin
						state_q <= ST_DIV_SIGN;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DIV_SIGN: begin
					if (!sel_den_q) begin
						res_q.res_num <= signed_q;
						rem_q         <= '0;
						dvd_q         <= magd_q;
						cnt_q         <= 6'(PROD_W - 1);
						sel_den_q     <= 1'b1;
						state_q       <= ST_DIV_STEP;
					end else begin
						res_q.res_den <= signed_q;
						res_q.status  <= wrap_q ? STATUS_WRAP : STATUS_OK;
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTH
	// a result strobe only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// an accepted transaction makes the unit busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// zero over zero is reported as 0/0
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_ZERO) |-> (result.res_num == '0 && result.res_den == '0))
		else $error("zero-over-zero status with nonzero result");

	// any other result has a nonzero side, since the gcd divides exactly
	a_nonzero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STATUS_ZERO) |-> (result.res_num != '0 || result.res_den != '0))
		else $error("reduced result lost both sides");
`endif

endmodule
